// ===== hw/rtl/rpbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbe_pkg
// Shared constants, codes, types and the gamma table of the LED pixel encoder.
// ----------------------------------------------------------------------------
package rpbe_pkg;

  localparam int SCALE_RESOLUTION_DEF = 256;
  localparam int BITS_PER_PIXEL       = 24;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [2:0] OP_BYTES         = 3'd0;
  localparam logic [2:0] OP_RGB565        = 3'd1;
  localparam logic [2:0] OP_RGB888        = 3'd2;
  localparam logic [2:0] OP_BYTES_BRIGHT  = 3'd3;
  localparam logic [2:0] OP_RGB565_BRIGHT = 3'd4;
  localparam logic [2:0] OP_RGB888_BRIGHT = 3'd5;

  localparam logic [1:0] ORDER_RGB = 2'd0;
  localparam logic [1:0] ORDER_BGR = 2'd1;
  localparam logic [1:0] ORDER_GRB = 2'd2;

  localparam logic [1:0] REG_CHANNEL_ORDER    = 2'd0;
  localparam logic [1:0] REG_GAMMA_ENABLE     = 2'd1;
  localparam logic [1:0] REG_ZERO_PULSE_WIDTH = 2'd2;
  localparam logic [1:0] REG_ONE_PULSE_WIDTH  = 2'd3;

  typedef struct packed {
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] bright;
    logic [7:0] peak;
  } pixel_t;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,
    8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,
    8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,
    8'd11,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,
    8'd18,8'd18,8'd19,8'd19,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,8'd25,
    8'd26,8'd27,8'd27,8'd28,
    8'd29,8'd29,8'd30,8'd31,8'd31,8'd32,8'd33,8'd34,8'd34,8'd35,8'd36,8'd37,8'd37,8'd38,
    8'd39,8'd40,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,8'd46,8'd47,8'd48,8'd49,8'd50,
    8'd51,8'd52,8'd53,8'd54,
    8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,
    8'd69,8'd70,8'd71,8'd72,8'd73,8'd74,8'd76,8'd77,8'd78,8'd79,8'd80,8'd81,8'd83,8'd84,
    8'd85,8'd86,8'd88,8'd89,
    8'd90,8'd91,8'd93,8'd94,8'd95,8'd96,8'd98,8'd99,8'd100,8'd102,8'd103,8'd104,8'd106,
    8'd107,8'd109,8'd110,8'd111,8'd113,8'd114,8'd116,8'd117,8'd119,8'd120,8'd121,8'd123,
    8'd124,8'd126,8'd128,8'd129,8'd131,8'd132,8'd134,
    8'd135,8'd137,8'd138,8'd140,8'd142,8'd143,8'd145,8'd146,8'd148,8'd150,8'd151,8'd153,
    8'd155,8'd157,8'd158,8'd160,8'd162,8'd163,8'd165,8'd167,8'd169,8'd170,8'd172,8'd174,
    8'd176,8'd178,8'd179,8'd181,8'd183,8'd185,8'd187,8'd189,
    8'd191,8'd193,8'd194,8'd196,8'd198,8'd200,8'd202,8'd204,8'd206,8'd208,8'd210,8'd212,
    8'd214,8'd216,8'd218,8'd220,8'd222,8'd224,8'd227,8'd229,8'd231,8'd233,8'd235,8'd237,
    8'd239,8'd241,8'd244,8'd246,8'd248,8'd250,8'd252,8'd255
  };

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] ab;
    ab = (a > b) ? a : b;
    return (ab > c) ? ab : c;
  endfunction

endpackage

// ===== hw/rtl/rpbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbe_front
// Input stage: unpacks the color format, picks brightness, applies gamma and
// wire order, and holds one classified pixel for the scaling unit.
// ----------------------------------------------------------------------------
module rpbe_front import rpbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [23:0] color_word,
  input  logic [7:0]  brightness,
  input  logic [1:0]  channel_order,
  input  logic        gamma_enable,
  output logic        pix_valid,
  output pixel_t      pix,
  input  logic        pix_take
);

  logic       op_ok;
  logic       accept;
  logic [7:0] r, g, b;
  logic [7:0] gr, gg, gb;
  pixel_t     pix_next;

  always_comb begin
    op_ok = 1'b1;
    r = red;
    g = green;
    b = blue;
    unique case (opcode) inside
      OP_BYTES, OP_BYTES_BRIGHT: begin
        r = red;
        g = green;
        b = blue;
      end
      OP_RGB565, OP_RGB565_BRIGHT: begin
        r = {color_word[15:11], 3'b000};
        g = {color_word[10:5], 2'b00};
        b = {color_word[4:0], 3'b000};
      end
      OP_RGB888, OP_RGB888_BRIGHT: begin
        r = color_word[23:16];
        g = color_word[15:8];
        b = color_word[7:0];
      end
      default: op_ok = 1'b0;
    endcase

    pix_next.bright = (opcode >= OP_BYTES_BRIGHT) ? brightness : max3(r, g, b);

    gr = gamma_enable ? GAMMA_LUT[r] : r;
    gg = gamma_enable ? GAMMA_LUT[g] : g;
    gb = gamma_enable ? GAMMA_LUT[b] : b;

    unique case (channel_order)
      ORDER_RGB: begin
        pix_next.s0 = gr;
        pix_next.s1 = gg;
        pix_next.s2 = gb;
      end
      ORDER_BGR: begin
        pix_next.s0 = gb;
        pix_next.s1 = gg;
        pix_next.s2 = gr;
      end
      default: begin
        pix_next.s0 = gg;
        pix_next.s1 = gr;
        pix_next.s2 = gb;
      end
    endcase

    pix_next.peak = max3(pix_next.s0, pix_next.s1, pix_next.s2);
  end

  assign full   = pix_valid && !pix_take;
  assign accept = push && !full;

  // drop unused opcodes at the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= (accept && op_ok) || (pix_valid && !pix_take);
      if (accept && op_ok) begin
        pix <= pix_next;
      end
    end
  end

endmodule

// ===== hw/rtl/rpbe_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbe_scale
// Scaling unit: radix-2 divider for the brightness scale, then one channel
// multiply and reciprocal-multiply per cycle to form the 24-bit color word.
// ----------------------------------------------------------------------------
module rpbe_scale import rpbe_pkg::*; #(
  parameter int SCALE_RESOLUTION = SCALE_RESOLUTION_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  input  pixel_t                    pix,
  output logic                      pix_take,
  output logic                      word_valid,
  output logic [BITS_PER_PIXEL-1:0] word,
  input  logic                      word_ready
);

  localparam int NUM_W   = $clog2(SCALE_RESOLUTION * 255 + 1);
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int PROD_W  = 24;
  localparam int SHIFT   = PROD_W + $clog2(SCALE_RESOLUTION);
  localparam int RECIP_W = PROD_W + 1;
  localparam int RP_W    = PROD_W + RECIP_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(SCALE_RESOLUTION) - 64'd1) / 64'(SCALE_RESOLUTION);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_DONE} state_t;

  state_t            state;
  pixel_t            s_hold;
  logic [7:0]        rem;
  logic [NUM_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        k;
  logic [PROD_W-1:0] prod;

  logic [8:0]        trial;
  logic [8:0]        diff;
  logic              ge;
  logic [7:0]        rem_next;
  logic [NUM_W-1:0]  quo_next;
  logic              sat;
  logic [15:0]       scale;
  logic [7:0]        chan;
  logic [PROD_W-1:0] mul;
  logic [RP_W-1:0]   rp;
  logic [RP_W-1:0]   rq;
  logic [7:0]        c;

  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    diff     = trial - {1'b0, s_hold.peak};
    ge       = (trial >= {1'b0, s_hold.peak});
    rem_next = ge ? diff[7:0] : trial[7:0];
    quo_next = {quo[NUM_W-2:0], ge};

    sat   = (quo > NUM_W'(16'hFFFF));
    scale = sat ? 16'hFFFF : 16'(quo);

    case (k)
      2'd0:    chan = s_hold.s0;
      2'd1:    chan = s_hold.s1;
      default: chan = s_hold.s2;
    endcase
    mul = {16'd0, chan} * {8'd0, scale};

    rp = RP_W'(prod) * RP_W'(RECIP[RECIP_W-1:0]);
    rq = rp >> SHIFT;
    c  = (rq > RP_W'(255)) ? 8'hFF : rq[7:0];
  end

  assign pix_take   = (state == S_IDLE) && pix_valid;
  assign word_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pix_valid) begin
            s_hold <= pix;
            rem    <= 8'd0;
            quo    <= NUM_W'(32'(SCALE_RESOLUTION) * {24'd0, pix.bright});
            cnt    <= '0;
            k      <= 2'd0;
            word   <= '0;
            state  <= (pix.bright == 8'd0 || pix.peak == 8'd0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (k != 2'd3) begin
            prod <= mul;
          end
          if (k != 2'd0) begin
            word <= {word[BITS_PER_PIXEL-9:0], c};
          end
          k <= k + 1'b1;
          if (k == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (word_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rpbe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbe_queue
// Small queue of color words between the scaling unit and the serializer.
// ----------------------------------------------------------------------------
module rpbe_queue import rpbe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int WIDTH = BITS_PER_PIXEL
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rpbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbe_back
// Serializer: shifts one color word out as 24 pulse widths, MSB first.
// ----------------------------------------------------------------------------
module rpbe_back import rpbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      word_valid,
  input  logic [BITS_PER_PIXEL-1:0] word,
  output logic                      word_pop,
  input  logic [15:0]               zero_pw,
  input  logic [15:0]               one_pw,
  output logic                      empty,
  input  logic                      pop,
  output logic [15:0]               pulse_width,
  output logic                      last_bit
);

  localparam int IDX_W = $clog2(BITS_PER_PIXEL);

  logic                      busy;
  logic [BITS_PER_PIXEL-1:0] shreg;
  logic [IDX_W-1:0]          idx;
  logic                      xfer;
  logic                      at_last;

  assign xfer        = pop && busy;
  assign at_last     = (idx == IDX_W'(BITS_PER_PIXEL - 1));
  assign word_pop    = word_valid && (!busy || (xfer && at_last));
  assign empty       = !busy;
  assign last_bit    = at_last;
  assign pulse_width = shreg[BITS_PER_PIXEL-1] ? one_pw : zero_pw;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (word_pop) begin
      busy  <= 1'b1;
      shreg <= word;
      idx   <= '0;
    end else if (xfer) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        shreg <= shreg << 1;
        idx   <= idx + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rgb_led_pixel_bit_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pixel_bit_encoder
// Path: the front stage holds a pixel, the one-bit-per-cycle scale divider
//   forms a NUM_W-bit quotient, NUM_W = clog2(255 * SCALE_RESOLUTION + 1)
//   (16 at the default); the word is then scaled, queued and serialized.
// Overlap: stages work on different pixels at once; the serializer sends one
//   line bit per cycle while pop is held, which bounds the default rate.
// Reset: synchronous rst empties all stages and restores register defaults.
// ----------------------------------------------------------------------------
module rgb_led_pixel_bit_encoder import rpbe_pkg::*; #(
  parameter int SCALE_RESOLUTION = SCALE_RESOLUTION_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [23:0] color_word,
  input  logic [7:0]  brightness,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pulse_width,
  output logic        last_bit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  channel_order;
  logic        gamma_enable;
  logic [15:0] zero_pulse_width;
  logic [15:0] one_pulse_width;
  logic        cfg_wr;

  logic                      pix_valid;
  pixel_t                    pix;
  logic                      pix_take;
  logic                      sc_valid;
  logic [BITS_PER_PIXEL-1:0] sc_word;
  logic                      sc_ready;
  logic                      q_valid;
  logic [BITS_PER_PIXEL-1:0] q_word;
  logic                      q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_order    <= ORDER_GRB;
      gamma_enable     <= 1'b0;
      zero_pulse_width <= 16'd0;
      one_pulse_width  <= 16'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CHANNEL_ORDER:    channel_order    <= pwdata[1:0];
        REG_GAMMA_ENABLE:     gamma_enable     <= pwdata[0];
        REG_ZERO_PULSE_WIDTH: zero_pulse_width <= pwdata[15:0];
        REG_ONE_PULSE_WIDTH:  one_pulse_width  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNEL_ORDER:    prdata = {30'd0, channel_order};
      REG_GAMMA_ENABLE:     prdata = {31'd0, gamma_enable};
      REG_ZERO_PULSE_WIDTH: prdata = {16'd0, zero_pulse_width};
      REG_ONE_PULSE_WIDTH:  prdata = {16'd0, one_pulse_width};
      default:              prdata = 32'd0;
    endcase
  end

  rpbe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .color_word    (color_word),
    .brightness    (brightness),
    .channel_order (channel_order),
    .gamma_enable  (gamma_enable),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .pix_take      (pix_take)
  );

  rpbe_scale #(
    .SCALE_RESOLUTION (SCALE_RESOLUTION)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .pix_take   (pix_take),
    .word_valid (sc_valid),
    .word       (sc_word),
    .word_ready (sc_ready)
  );

  rpbe_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (BITS_PER_PIXEL)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (sc_valid),
    .wr_data  (sc_word),
    .wr_ready (sc_ready),
    .rd_valid (q_valid),
    .rd_data  (q_word),
    .rd_ready (q_pop)
  );

  rpbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .word_valid  (q_valid),
    .word        (q_word),
    .word_pop    (q_pop),
    .zero_pw     (zero_pulse_width),
    .one_pw      (one_pulse_width),
    .empty       (empty),
    .pop         (pop),
    .pulse_width (pulse_width),
    .last_bit    (last_bit)
  );

  a_bits_contiguous: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_bit) |=> !empty)
    else $error("pixel bit stream broke before its last bit");

  a_width_is_configured: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pulse_width == zero_pulse_width || pulse_width == one_pulse_width))
    else $error("pulse width is neither configured value");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("serializer loaded from an empty queue");

endmodule
